FILE: rtl/l2dt_pkg.sv
// Shared types, codes and defaults for the toroidal Life stepper.
`timescale 1ns / 1ps
package l2dt_pkg;

  localparam int SIDE_DEF     = 64;
  localparam int AGE_BITS_DEF = 16;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  // B3/S23 neighbor counts.
  localparam logic [3:0] NBR_SURVIVE = 4'd2;
  localparam logic [3:0] NBR_BIRTH   = 4'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic       alive_in;
  } in_t;

  typedef struct packed {
    logic        alive_out;
    logic [15:0] age_out;
    logic        stepped;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ITEM_WR,
    ST_LD_PREV,
    ST_LD_CUR,
    ST_LD_NXT,
    ST_LD_WAIT,
    ST_CELL,
    ST_ROW_END,
    ST_ROW_WB,
    ST_ROW_LD,
    ST_FIN
  } state_t;

  // Which grid row the alive memory reads during a generation.
  typedef enum logic [1:0] {
    ROW_LAST,
    ROW_FIRST,
    ROW_SECOND,
    ROW_AHEAD
  } row_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     item_rd;
    logic     item_wr;
    logic     clr_wr;
    logic     row_rd;
    row_sel_t row_sel;
    logic     ld_prev;
    logic     ld_cur;
    logic     ld_nxt;
    logic     ld_nxt_row0;
    logic     row_wb;
    logic     cell_go;
    logic     load_out;
    logic     stepped;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       on_grid;
  } stat_t;

endpackage

FILE: rtl/l2dt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module l2dt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/l2dt_ctrl.sv
// Controller: sequencing of clear, item access and generation sweep.
`timescale 1ns / 1ps
module l2dt_ctrl #(
  parameter int SIDE = l2dt_pkg::SIDE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  l2dt_pkg::stat_t         stat,
  output l2dt_pkg::cmd_t          cmd,
  output logic [$clog2(SIDE)-1:0] r,
  output logic [$clog2(SIDE)-1:0] c
);

  localparam int RW = $clog2(SIDE);
  localparam logic [RW-1:0] C_LAST = RW'(SIDE - 1);

  l2dt_pkg::state_t state, state_next;
  logic [RW-1:0] r_next, c_next;
  logic          run_enable;
  logic          did_step, did_step_next;
  logic          rsp_valid_next;
  logic [RW:0]   r_ahead;
  logic          ahead_wrap;

  assign r_ahead    = {1'b0, r} + (RW + 1)'(2);
  assign ahead_wrap = (r_ahead == (RW + 1)'(SIDE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= l2dt_pkg::ST_CLEAR;
      r          <= '0;
      c          <= '0;
      run_enable <= 1'b0;
      did_step   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      r         <= r_next;
      c         <= c_next;
      did_step  <= did_step_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) begin
        run_enable <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next     = state;
    r_next         = r;
    c_next         = c;
    did_step_next  = did_step;
    rsp_valid_next = rsp_valid;
    cmd            = '0;
    cmd.row_sel    = l2dt_pkg::ROW_LAST;
    cmd.stepped    = did_step;
    req_ready      = (state == l2dt_pkg::ST_IDLE);
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    unique case (state)
      l2dt_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (c == C_LAST) begin
          c_next = '0;
          if (r == C_LAST) begin
            r_next     = '0;
            state_next = l2dt_pkg::ST_IDLE;
          end else begin
            r_next = r + 1'b1;
          end
        end else begin
          c_next = c + 1'b1;
        end
      end
      l2dt_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          did_step_next = 1'b0;
          state_next    = l2dt_pkg::ST_DISPATCH;
        end
      end
      l2dt_pkg::ST_DISPATCH: begin
        if ((stat.kind == l2dt_pkg::KIND_WRITE || stat.kind == l2dt_pkg::KIND_READ)
            && stat.on_grid) begin
          cmd.item_rd = 1'b1;
        end
        unique case (stat.kind)
          l2dt_pkg::KIND_WRITE: begin
            state_next = stat.on_grid ? l2dt_pkg::ST_ITEM_WR : l2dt_pkg::ST_FIN;
          end
          l2dt_pkg::KIND_STEP: begin
            if (run_enable) begin
              did_step_next = 1'b1;
              r_next        = '0;
              c_next        = '0;
              state_next    = l2dt_pkg::ST_LD_PREV;
            end else begin
              state_next = l2dt_pkg::ST_FIN;
            end
          end
          default: begin
            state_next = l2dt_pkg::ST_FIN;
          end
        endcase
      end
      l2dt_pkg::ST_ITEM_WR: begin
        cmd.item_wr = 1'b1;
        state_next  = l2dt_pkg::ST_FIN;
      end
      l2dt_pkg::ST_LD_PREV: begin
        cmd.row_rd  = 1'b1;
        cmd.row_sel = l2dt_pkg::ROW_LAST;
        state_next  = l2dt_pkg::ST_LD_CUR;
      end
      l2dt_pkg::ST_LD_CUR: begin
        cmd.row_rd  = 1'b1;
        cmd.row_sel = l2dt_pkg::ROW_FIRST;
        cmd.ld_prev = 1'b1;
        state_next  = l2dt_pkg::ST_LD_NXT;
      end
      l2dt_pkg::ST_LD_NXT: begin
        cmd.row_rd  = 1'b1;
        cmd.row_sel = l2dt_pkg::ROW_SECOND;
        cmd.ld_cur  = 1'b1;
        state_next  = l2dt_pkg::ST_LD_WAIT;
      end
      l2dt_pkg::ST_LD_WAIT: begin
        cmd.ld_nxt = 1'b1;
        state_next = l2dt_pkg::ST_CELL;
      end
      l2dt_pkg::ST_CELL: begin
        cmd.cell_go = 1'b1;
        if (c == C_LAST) begin
          c_next     = '0;
          state_next = l2dt_pkg::ST_ROW_END;
        end else begin
          c_next = c + 1'b1;
        end
      end
      l2dt_pkg::ST_ROW_END: begin
        state_next = l2dt_pkg::ST_ROW_WB;
      end
      l2dt_pkg::ST_ROW_WB: begin
        cmd.row_wb = 1'b1;
        if (r == C_LAST) begin
          state_next = l2dt_pkg::ST_FIN;
        end else begin
          if (!ahead_wrap) begin
            cmd.row_rd  = 1'b1;
            cmd.row_sel = l2dt_pkg::ROW_AHEAD;
          end
          state_next = l2dt_pkg::ST_ROW_LD;
        end
      end
      l2dt_pkg::ST_ROW_LD: begin
        if (ahead_wrap) begin
          cmd.ld_nxt_row0 = 1'b1;
        end else begin
          cmd.ld_nxt = 1'b1;
        end
        r_next     = r + 1'b1;
        state_next = l2dt_pkg::ST_CELL;
      end
      l2dt_pkg::ST_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = l2dt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = l2dt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    (c <= C_LAST) && (r <= C_LAST))
    else $error("row or column counter left the grid");

  a_last_row_done: assert property (@(posedge clk) disable iff (rst)
    (state == l2dt_pkg::ST_ROW_WB && r == C_LAST) |=> (state == l2dt_pkg::ST_FIN))
    else $error("generation sweep did not finish after the last row");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("result load did not raise rsp_valid");

  a_step_flag: assert property (@(posedge clk) disable iff (rst)
    (state == l2dt_pkg::ST_CELL) |-> did_step)
    else $error("cell sweep running without a step flagged");
`endif

endmodule

FILE: rtl/l2dt_dp.sv
// Datapath: cell memories, row window, B3/S23 update and result register.
`timescale 1ns / 1ps
module l2dt_dp #(
  parameter int SIDE     = l2dt_pkg::SIDE_DEF,
  parameter int AGE_BITS = l2dt_pkg::AGE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  l2dt_pkg::in_t           req,
  output l2dt_pkg::out_t          rsp,
  input  l2dt_pkg::cmd_t          cmd,
  output l2dt_pkg::stat_t         stat,
  input  logic [$clog2(SIDE)-1:0] r,
  input  logic [$clog2(SIDE)-1:0] c
);

  localparam int RW    = $clog2(SIDE);
  localparam int CELLW = $clog2(SIDE * SIDE);
  localparam int XW    = (RW > 6) ? RW : 6;
  localparam int AXW   = (AGE_BITS > 16) ? AGE_BITS : 16;

  l2dt_pkg::in_t  item;
  l2dt_pkg::out_t out_reg;

  logic [XW-1:0]    col_x, row_x;
  logic [RW-1:0]    icol, irow;
  logic [CELLW-1:0] iaddr, caddr, addr_d;
  logic [RW:0]      r_ahead;

  logic [SIDE-1:0] prev_row, cur_row, nxt_row, row0, new_row;

  logic            a_we, a_re;
  logic [RW-1:0]   a_waddr, a_raddr;
  logic [SIDE-1:0] a_wdata, a_rdata;

  logic                g_we, g_re;
  logic [CELLW-1:0]    g_waddr, g_raddr;
  logic [AGE_BITS-1:0] g_wdata, g_rdata, age_new;
  logic [AXW-1:0]      age_x;
  logic [15:0]         age_sat;

  logic          cell_go_d;
  logic [RW-1:0] col_d, col_m, col_p;
  logic [3:0]    nbr;
  logic          self_alive, nx, rd_hit;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
  end

  assign col_x        = XW'(item.col);
  assign row_x        = XW'(item.row);
  assign icol         = col_x[RW-1:0];
  assign irow         = row_x[RW-1:0];
  assign stat.kind    = item.kind;
  assign stat.on_grid = ({1'b0, col_x} < (XW + 1)'(SIDE)) && ({1'b0, row_x} < (XW + 1)'(SIDE));

  assign iaddr   = CELLW'(irow) * CELLW'(SIDE) + CELLW'(icol);
  assign caddr   = CELLW'(r) * CELLW'(SIDE) + CELLW'(c);
  assign r_ahead = {1'b0, r} + (RW + 1)'(2);

  // Alive memory: one word per grid row.
  always_comb begin
    a_we    = cmd.clr_wr | cmd.item_wr | cmd.row_wb;
    a_waddr = cmd.item_wr ? irow : r;
    a_wdata = '0;
    if (cmd.item_wr) begin
      a_wdata       = a_rdata;
      a_wdata[icol] = item.alive_in;
    end else if (cmd.row_wb) begin
      a_wdata = new_row;
    end
    a_re = cmd.row_rd | cmd.item_rd;
    if (cmd.item_rd) begin
      a_raddr = irow;
    end else begin
      unique case (cmd.row_sel)
        l2dt_pkg::ROW_LAST:   a_raddr = RW'(SIDE - 1);
        l2dt_pkg::ROW_FIRST:  a_raddr = '0;
        l2dt_pkg::ROW_SECOND: a_raddr = RW'(1);
        l2dt_pkg::ROW_AHEAD:  a_raddr = r_ahead[RW-1:0];
        default:              a_raddr = '0;
      endcase
    end
  end

  l2dt_ram #(
    .WIDTH(SIDE),
    .DEPTH(SIDE)
  ) u_alive_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .re   (a_re),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  // Age memory: one word per cell.
  assign g_we    = cmd.clr_wr | cmd.item_wr | cell_go_d;
  assign g_waddr = cell_go_d ? addr_d : (cmd.item_wr ? iaddr : caddr);
  assign g_wdata = cell_go_d ? age_new : '0;
  assign g_re    = cmd.item_rd | cmd.cell_go;
  assign g_raddr = cmd.item_rd ? iaddr : caddr;

  l2dt_ram #(
    .WIDTH(AGE_BITS),
    .DEPTH(SIDE * SIDE)
  ) u_age_ram (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_waddr),
    .wdata(g_wdata),
    .re   (g_re),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  // Cell pipe: age read issued in the cycle before the update.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_go_d <= 1'b0;
    end else begin
      cell_go_d <= cmd.cell_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_go) begin
      col_d  <= c;
      addr_d <= caddr;
    end
  end

  assign col_m = (col_d == '0) ? RW'(SIDE - 1) : col_d - 1'b1;
  assign col_p = (col_d == RW'(SIDE - 1)) ? '0 : col_d + 1'b1;

  assign nbr = 4'(prev_row[col_m]) + 4'(prev_row[col_d]) + 4'(prev_row[col_p])
             + 4'(cur_row[col_m])                        + 4'(cur_row[col_p])
             + 4'(nxt_row[col_m])  + 4'(nxt_row[col_d])  + 4'(nxt_row[col_p]);

  assign self_alive = cur_row[col_d];
  assign nx         = (nbr == l2dt_pkg::NBR_BIRTH)
                    | (self_alive & (nbr == l2dt_pkg::NBR_SURVIVE));

  always_comb begin
    if (self_alive && nx) begin
      age_new = (g_rdata == '1) ? g_rdata : g_rdata + AGE_BITS'(1);
    end else begin
      age_new = '0;
    end
  end

  // Row window: previous, current and next generation-old rows.
  always_ff @(posedge clk) begin
    if (cmd.ld_prev) begin
      prev_row <= a_rdata;
    end
    if (cmd.ld_cur) begin
      cur_row <= a_rdata;
      row0    <= a_rdata;
    end
    if (cmd.ld_nxt) begin
      nxt_row <= a_rdata;
    end
    if (cmd.ld_nxt_row0) begin
      nxt_row <= row0;
    end
    if (cmd.row_wb) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
    if (cell_go_d) begin
      new_row[col_d] <= nx;
    end
  end

  // Result register.
  assign age_x   = AXW'(g_rdata);
  assign age_sat = (age_x > AXW'(16'hFFFF)) ? 16'hFFFF : age_x[15:0];
  assign rd_hit  = (item.kind == l2dt_pkg::KIND_READ) && stat.on_grid;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_reg.alive_out <= rd_hit & a_rdata[icol];
      out_reg.age_out   <= rd_hit ? age_sat : 16'd0;
      out_reg.stepped   <= cmd.stepped;
    end
  end

  assign rsp = out_reg;

endmodule

FILE: rtl/life_2d_torus_step.sv
// Top level of the toroidal B3/S23 Life stepper with per-cell ages.
`timescale 1ns / 1ps
// Write and read beats give their result one beat at a time.
// A step beat sweeps the grid one cell per cycle through the dual-port age memory,
//   pausing at the end of each row for the row write-back and the look-ahead row
//   fetch of the alive memory.
// After reset a clearing pass writes every cell with req_ready low; run_enable
//   resets to 0 and may be written during the pass.
module life_2d_torus_step #(
  parameter int SIDE     = l2dt_pkg::SIDE_DEF,
  parameter int AGE_BITS = l2dt_pkg::AGE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // request beats: write, read or step
  input  logic           req_valid,
  output logic           req_ready,
  input  l2dt_pkg::in_t  req,
  // one result beat per request
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output l2dt_pkg::out_t rsp,
  // run_enable register
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  l2dt_pkg::cmd_t          cmd;
  l2dt_pkg::stat_t         stat;
  // Sweep counters: grid row and column under work.
  logic [$clog2(SIDE)-1:0] r, c;

  // The sequencer owns the handshakes, the run_enable bit and the sweep order:
  // clear pass, item dispatch, row preload, per-cell sweep and row write-back.
  l2dt_ctrl #(
    .SIDE(SIDE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .stat     (stat),
    .cmd      (cmd),
    .r        (r),
    .c        (c)
  );

  // The datapath holds the alive memory (one word per row) and the age memory
  // (one word per cell), a three-row window of the old generation plus a saved
  // copy of row 0 for the wrap at the bottom edge, and the result register,
  // which lets a new request be accepted while a result still waits.
  l2dt_dp #(
    .SIDE    (SIDE),
    .AGE_BITS(AGE_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .stat(stat),
    .r   (r),
    .c   (c)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the toroidal B3/S23 Life stepper: random handshakes, full-grid model.
`timescale 1ns / 1ps
module testbench;

  localparam int SIDE  = l2dt_pkg::SIDE_DEF;
  localparam int CELLS = SIDE * SIDE;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LONG_HOLD = 400;  // receiver hold-off, in cycles

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  l2dt_pkg::in_t  req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  l2dt_pkg::out_t rsp;
  logic           cfg_we = 1'b0;
  logic           cfg_wdata = 1'b0;

  life_2d_torus_step u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period: high and low halves.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the grid, the ages and the run_enable register.
  bit          live_grid [CELLS];
  bit          next_live [CELLS];
  bit [15:0]   age_grid  [CELLS];
  bit          run_on;

  l2dt_pkg::in_t  beats_todo[$];    // request beats waiting for the driver
  l2dt_pkg::out_t results_due[$];   // results owed by the block, oldest first

  int unsigned mismatches;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          steps_left = 24;  // cap on deliberate generation steps in the random part
  bit          hold_trigger;     // toggle to ask the receiver for one long hold-off

  // Compute the next generation of every cell from the current one, wrapping at the edges.
  function automatic void advance_generation();
    int nbrs;
    int idx;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        nbrs = 0;
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            if (dr != 1 || dc != 1)
              nbrs += live_grid[((r + SIDE + dr - 1) % SIDE) * SIDE + (c + SIDE + dc - 1) % SIDE];
          end
        end
        idx = r * SIDE + c;
        next_live[idx] = live_grid[idx]
                       ? (nbrs == l2dt_pkg::NBR_SURVIVE || nbrs == l2dt_pkg::NBR_BIRTH)
                       : (nbrs == l2dt_pkg::NBR_BIRTH);
        // Survivors age, saturating; everything else restarts at zero.
        if (live_grid[idx] && next_live[idx]) begin
          if (age_grid[idx] != 16'hFFFF) age_grid[idx] = age_grid[idx] + 16'd1;
        end else begin
          age_grid[idx] = '0;
        end
      end
    end
    live_grid = next_live;
  endfunction

  // Apply one accepted request beat to the shadow state and return the result it owes.
  function automatic l2dt_pkg::out_t predict_beat(l2dt_pkg::in_t b);
    l2dt_pkg::out_t res;
    bit             on_grid;
    int             idx;
    res     = '0;
    on_grid = (b.col < SIDE) && (b.row < SIDE);
    idx     = on_grid ? b.row * SIDE + b.col : 0;
    case (b.kind)
      l2dt_pkg::KIND_WRITE: begin
        if (on_grid) begin
          live_grid[idx] = b.alive_in;
          age_grid[idx]  = '0;
        end
      end
      l2dt_pkg::KIND_READ: begin
        if (on_grid) begin
          res.alive_out = live_grid[idx];
          res.age_out   = age_grid[idx];
        end
      end
      l2dt_pkg::KIND_STEP: begin
        if (run_on) begin
          advance_generation();
          res.stepped = 1'b1;
        end
      end
      default: ;  // unused kind: no effect, all-zero result
    endcase
    return res;
  endfunction

  function automatic l2dt_pkg::in_t mk_beat(logic [1:0] kind, int col, int row, bit alive);
    l2dt_pkg::in_t b;
    b.kind     = kind;
    b.col      = col[5:0];
    b.row      = row[5:0];
    b.alive_in = alive;
    return b;
  endfunction

  // Driver: predict on acceptance, then refill the request slot from the queue.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready)
        results_due.push_back(predict_beat(req));
      // The slot is free once the current beat goes or if none was offered.
      if (!req_valid || req_ready) begin
        if (beats_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req       <= beats_todo.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation, and drive rsp_ready.
  int unsigned hold_left;
  bit          hold_seen;

  always @(posedge clk) begin : monitor
    l2dt_pkg::out_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no expectation pending: %p", rsp);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (rsp.alive_out !== want.alive_out) begin
            $error("alive_out: expected %0d, actual %0d", want.alive_out, rsp.alive_out);
            mismatches++;
          end
          if (rsp.age_out !== want.age_out) begin
            $error("age_out: expected %0d, actual %0d", want.age_out, rsp.age_out);
            mismatches++;
          end
          if (rsp.stepped !== want.stepped) begin
            $error("stepped: expected %0d, actual %0d", want.stepped, rsp.stepped);
            mismatches++;
          end
        end
      end
      // Start a long hold-off on request and count it down here, by one per clock.
      if (hold_trigger != hold_seen) begin
        hold_seen <= hold_trigger;
        hold_left <= LONG_HOLD;
        rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Write run_enable; called only while nothing is in flight.
  task automatic write_run_enable(bit value);
    @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_on  = value;
  endtask

  // Hold until every queued beat is accepted and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (beats_todo.size() != 0 || req_valid || results_due.size() != 0);
  endtask

  // Random traffic: mostly writes and reads clustered around a moving origin so that
  // patterns form and evolve, some steps, and a little fully random noise.
  task automatic queue_random(int count, bit allow_steps);
    int            ox;
    int            oy;
    int            pick;
    l2dt_pkg::in_t b;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        ox = $urandom_range(63);
        oy = $urandom_range(63);
      end
      pick = $urandom_range(99);
      b    = ($bits(l2dt_pkg::in_t))'($urandom);
      if (pick < 8) begin
        // noise: every field random, the unused kind included
      end else if (pick < 20 && allow_steps && steps_left > 0) begin
        b.kind = l2dt_pkg::KIND_STEP;
        steps_left--;
      end else if (pick < 45) begin
        b = mk_beat(l2dt_pkg::KIND_READ, ox - 1 + $urandom_range(7),
                    oy - 1 + $urandom_range(7), $urandom_range(1));
      end else begin
        b = mk_beat(l2dt_pkg::KIND_WRITE, ox + $urandom_range(5), oy + $urandom_range(5),
                    $urandom_range(99) < 70);
      end
      beats_todo.push_back(b);
    end
  endtask

  initial begin
    tx_idle_pct = 30;
    rx_idle_pct = 60;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Disabled: seed a blinker across the column wrap and a block, poke the corners,
    // and check that a step does nothing.
    @(negedge clk);
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  0,  0, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 62, 0, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 63, 0, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 0,  0, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 30, 30, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 31, 30, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 30, 31, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 31, 31, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 5,  5, 1'b0));
    beats_todo.push_back(mk_beat(KIND_UNUSED,          63, 63, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_STEP,  63, 63, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  63, 0, 1'b0));
    drain();

    // Enabled: the blinker flips across the row wrap, the block ages, a rewrite clears age.
    write_run_enable(1'b1);
    @(negedge clk);
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_STEP,  0,  0, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  63, 63, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  63, 0, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  63, 1, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  30, 30, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_STEP,  0,  0, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  31, 30, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  62, 0, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_WRITE, 31, 31, 1'b1));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  31, 31, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_STEP,  0,  0, 1'b0));
    beats_todo.push_back(mk_beat(l2dt_pkg::KIND_READ,  30, 31, 1'b0));
    drain();

    queue_random(25, 1'b1);
    drain();

    // Swap the idle ratios and run with stepping off, then on again.
    tx_idle_pct = 60;
    rx_idle_pct = 30;
    write_run_enable(1'b0);
    @(negedge clk);
    queue_random(25, 1'b1);
    drain();

    write_run_enable(1'b1);
    @(negedge clk);
    queue_random(25, 1'b1);
    drain();

    // No idling; stall the receiver for a long stretch while requests keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(20, 1'b0);
    hold_trigger = ~hold_trigger;
    queue_random(20, 1'b1);
    drain();

    // Let any stray result show up before the verdict.
    repeat (20) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog: several times the slowest legal run (clear pass plus a full sweep per beat).
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/l2dt_pkg.sv
rtl/l2dt_ram.sv
rtl/l2dt_ctrl.sv
rtl/l2dt_dp.sv
rtl/life_2d_torus_step.sv
tb/testbench.sv
